FILE: rtl/core/htw_pkg.sv
// Package for the hashed timing wheel: sizes, request/status codes and the
// beat and control structs shared by the wheel cells, the divider and the top.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package htw_pkg;

  localparam int SLOTS  = 64;               // power of two
  localparam int TIMERS = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int ID_W   = 4;
  localparam int TO_W   = 32;
  localparam int TI_W   = 16;
  localparam int ROT_W  = TO_W - SLOT_W;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_DEL  = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NONE = 2'd3
  } htw_req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEG      = 2'd1,
    ST_FULL     = 2'd2,
    ST_INACTIVE = 2'd3
  } htw_status_e;

  typedef struct packed {
    htw_req_e                req_type;
    logic signed [TO_W-1:0]  timeout;
    logic [ID_W-1:0]         timer_id;
  } htw_req_t;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    htw_status_e     status;
    logic            expired;
    logic            last;
  } htw_rsp_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              adv;
    logic [SLOT_W-1:0] slot_ptr;
    logic [SLOT_W-1:0] wr_slot;
    logic [ROT_W-1:0]  wr_rot;
  } htw_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/htw_cell.sv
// One timer entry of the wheel: active flag, slot and rotation count, plus
// the stage of the tick token chain. Depends on htw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htw_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  htw_pkg::htw_ctl_t ctl_i,
  input  logic              add_i,
  input  logic              del_i,
  input  logic              tok_i,
  output logic              tok_o,
  output logic              active_o,
  output logic              exp_o
);
  import htw_pkg::*;

  logic              tok_q;
  logic              active_q;
  logic [SLOT_W-1:0] slot_q;
  logic [ROT_W-1:0]  rot_q;
  logic              hit;

  // token sits here and the entry belongs to the current slot
  assign hit      = ctl_i.adv && tok_q && active_q && (slot_q == ctl_i.slot_ptr);
  assign exp_o    = hit && (rot_q == '0);
  assign tok_o    = tok_q;
  assign active_o = active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= 1'b0;
      active_q <= 1'b0;
    end else begin
      if (ctl_i.adv) begin
        tok_q <= tok_i;
      end
      if (add_i) begin
        active_q <= 1'b1;
      end else if (del_i || exp_o) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_i) begin
      slot_q <= ctl_i.wr_slot;
      rot_q  <= ctl_i.wr_rot;
    end else if (hit && (rot_q != '0)) begin
      rot_q <= rot_q - ROT_W'(1);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/htw_div.sv
// Restoring divider, two quotient bits per cycle, for timeout / tick interval.
// Depends on htw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htw_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [htw_pkg::TO_W-1:0] dividend_i,
  input  logic [htw_pkg::TI_W-1:0] divisor_i,
  output logic                    done_o,
  output logic [htw_pkg::TO_W-1:0] quot_o
);
  import htw_pkg::*;

  localparam int STEPS = TO_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [TI_W-1:0]  div_q;
  logic [TI_W-1:0]  rem_q;
  logic [TO_W-1:0]  dq_q;     // dividend shifts out, quotient shifts in

  logic [TI_W:0]    r1;
  logic [TI_W:0]    r2;
  logic             ge1;
  logic             ge2;
  logic [TI_W-1:0]  rem_d;
  logic [TO_W-1:0]  dq_d;

  always_comb begin
    r1 = {rem_q, dq_q[TO_W-1]};
    ge1 = (r1 >= {1'b0, div_q});
    if (ge1) begin
      r1 = r1 - {1'b0, div_q};
    end
    r2 = {r1[TI_W-1:0], dq_q[TO_W-2]};
    ge2 = (r2 >= {1'b0, div_q});
    if (ge2) begin
      r2 = r2 - {1'b0, div_q};
    end
    rem_d = r2[TI_W-1:0];
    dq_d  = {dq_q[TO_W-3:0], ge1, ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      dq_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

`default_nettype wire

FILE: rtl/core/hashed_timing_wheel.sv
// Hashed timing wheel: 64 slots, 16 timer entries held in a chain of cells.
// One item at a time. Delete, and an add that is refused, go from the
// request register straight to the output register. An accepted add waits
// on the two-bit-per-cycle divider. Tick: a token walks the 16 cells one per
// cycle; it pauses while the output register is full. Results sit in an output
// register, so the next item is taken while the last result waits. Reset frees all
// entries, sets the current slot to 0 and the tick interval to 1.
`timescale 1ns / 1ps
`default_nettype none

module hashed_timing_wheel (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  htw_pkg::htw_req_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output htw_pkg::htw_rsp_t         out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [htw_pkg::TI_W-1:0]  cfg_data_i
);
  import htw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_ADDW,
    S_TICK,
    S_FLUSH
  } state_e;

  state_e            state_q, state_d;
  htw_req_t          req_q;
  logic [TI_W-1:0]   tick_int_q;
  logic [SLOT_W-1:0] slot_ptr_q, slot_ptr_d;
  logic              inj_q, inj_d;
  logic              pend_v_q, pend_v_d;
  logic [ID_W-1:0]   pend_id_q, pend_id_d;
  logic              out_valid_q;
  htw_rsp_t          out_q;

  logic              out_free;
  logic              out_we;
  htw_rsp_t          out_d;

  logic [TIMERS-1:0] active_vec;
  logic [TIMERS-1:0] exp_vec;
  logic [TIMERS-1:0] add_vec;
  logic [TIMERS-1:0] del_vec;
  logic [TIMERS:0]   tok;
  htw_ctl_t          ctl;

  logic              free_v;
  logic [ID_W-1:0]   free_id;
  logic [ID_W-1:0]   exp_id;
  logic              exp_any;
  logic              del_hit;
  logic [TI_W-1:0]   si;
  logic              div_start;
  logic              div_done;
  logic [TO_W-1:0]   quot;
  logic [TO_W-1:0]   ticks;
  logic [SLOT_W:0]   slot_sum;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign si = (tick_int_q == '0) ? TI_W'(1) : tick_int_q;

  // lowest free entry, and the id of the cell that expires under the token
  always_comb begin
    free_v  = 1'b0;
    free_id = '0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (!active_vec[i]) begin
        free_v  = 1'b1;
        free_id = ID_W'(i);
      end
    end
  end

  always_comb begin
    exp_id = '0;
    for (int i = 0; i < TIMERS; i++) begin
      if (exp_vec[i]) begin
        exp_id = exp_id | ID_W'(i);
      end
    end
  end

  assign exp_any = |exp_vec;
  assign del_hit = (32'(req_q.timer_id) < 32'(TIMERS)) && active_vec[req_q.timer_id];

  // timeouts below the interval give a zero quotient and take one tick
  assign ticks    = (quot == '0) ? TO_W'(1) : quot;
  assign slot_sum = {1'b0, ticks[SLOT_W-1:0]} + {1'b0, slot_ptr_q};

  always_comb begin
    ctl.adv      = (state_q == S_TICK) && out_free;
    ctl.slot_ptr = slot_ptr_q;
    ctl.wr_rot   = ticks[TO_W-1:SLOT_W];
    if (slot_sum >= (SLOT_W + 1)'(SLOTS)) begin
      ctl.wr_slot = SLOT_W'(slot_sum - (SLOT_W + 1)'(SLOTS));
    end else begin
      ctl.wr_slot = slot_sum[SLOT_W-1:0];
    end
  end

  assign div_start = (state_q == S_EXEC) && (req_q.req_type == REQ_ADD) &&
                     !req_q.timeout[TO_W-1] && free_v;

  always_comb begin
    add_vec = '0;
    del_vec = '0;
    if ((state_q == S_ADDW) && out_free) begin
      add_vec[free_id] = 1'b1;
    end
    if ((state_q == S_EXEC) && (req_q.req_type == REQ_DEL) && out_free && del_hit) begin
      del_vec[req_q.timer_id] = 1'b1;
    end
  end

  htw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (req_q.timeout),
    .divisor_i  (si),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign tok[0] = inj_q;

  for (genvar g = 0; g < TIMERS; g++) begin : g_cell
    htw_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .add_i    (add_vec[g]),
      .del_i    (del_vec[g]),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .active_o (active_vec[g]),
      .exp_o    (exp_vec[g])
    );
  end

  always_comb begin
    state_d    = state_q;
    slot_ptr_d = slot_ptr_q;
    inj_d      = inj_q;
    pend_v_d   = pend_v_q;
    pend_id_d  = pend_id_q;
    out_we     = 1'b0;
    out_d      = '{result_id: '0, status: ST_OK, expired: 1'b0, last: 1'b1};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (req_q.req_type)
          REQ_ADD: begin
            if (req_q.timeout[TO_W-1]) begin
              if (out_free) begin
                out_we       = 1'b1;
                out_d.status = ST_NEG;
                state_d      = S_IDLE;
              end
            end else if (!free_v) begin
              if (out_free) begin
                out_we       = 1'b1;
                out_d.status = ST_FULL;
                state_d      = S_IDLE;
              end
            end else begin
              state_d = S_DIV;
            end
          end
          REQ_DEL: begin
            if (out_free) begin
              out_we          = 1'b1;
              out_d.result_id = req_q.timer_id;
              out_d.status    = del_hit ? ST_OK : ST_INACTIVE;
              state_d         = S_IDLE;
            end
          end
          REQ_TICK: begin
            inj_d    = 1'b1;
            pend_v_d = 1'b0;
            state_d  = S_TICK;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_ADDW;
        end
      end
      S_ADDW: begin
        if (out_free) begin
          out_we          = 1'b1;
          out_d.result_id = free_id;
          state_d         = S_IDLE;
        end
      end
      S_TICK: begin
        // hold back each expiry until the next one is found so the final one can carry last
        if (ctl.adv) begin
          inj_d = 1'b0;
          if (exp_any) begin
            if (pend_v_q) begin
              out_we          = 1'b1;
              out_d.result_id = pend_id_q;
              out_d.expired   = 1'b1;
              out_d.last      = 1'b0;
            end
            pend_v_d  = 1'b1;
            pend_id_d = exp_id;
          end
          if (tok[TIMERS]) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_we = 1'b1;
          if (pend_v_q) begin
            out_d.result_id = pend_id_q;
            out_d.expired   = 1'b1;
          end
          pend_v_d = 1'b0;
          if (slot_ptr_q == SLOT_W'(SLOTS - 1)) begin
            slot_ptr_d = '0;
          end else begin
            slot_ptr_d = slot_ptr_q + SLOT_W'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_int_q  <= TI_W'(1);
      slot_ptr_q  <= '0;
      inj_q       <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      slot_ptr_q <= slot_ptr_d;
      inj_q      <= inj_d;
      pend_v_q   <= pend_v_d;
      if (cfg_valid_i) begin
        tick_int_q <= cfg_data_i;
      end
      if (out_we) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    if (out_we) begin
      out_q <= out_d;
    end
    if ((state_q == S_IDLE) && in_valid_i) begin
      req_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for hashed_timing_wheel: drives add/delete/tick and
// unused request beats and checks every result beat against a cycle-free model of
// the wheel state. Depends on htw_pkg and the hashed_timing_wheel RTL.
`timescale 1ns / 1ps

module tb_top;
  import htw_pkg::*;

  // Predicts wheel results and holds them until the DUT produces them.
  class wheel_scoreboard;
    bit [TI_W-1:0]   interval;
    bit              active [TIMERS];
    bit [SLOT_W-1:0] slot_of [TIMERS];
    bit [ROT_W-1:0]  turns_left [TIMERS];
    bit [SLOT_W-1:0] slot_ptr;
    htw_rsp_t        expected_rsp [$];
    int              mismatches;

    function new();
      interval = 1;
      slot_ptr = '0;
      mismatches = 0;
      foreach (active[i]) active[i] = 1'b0;
    endfunction

    function void set_interval(bit [TI_W-1:0] v);
      interval = v;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    function void note_request(htw_req_t req);
      htw_rsp_t    r;
      htw_rsp_t    hits [$];
      bit [31:0]   tmo;
      bit [31:0]   div;
      bit [31:0]   ticks;
      int          free_id;
      r = '0;
      r.status = ST_OK;
      r.last = 1'b1;
      tmo = req.timeout;
      case (req.req_type)
        REQ_ADD: begin
          div = (interval == 0) ? 32'd1 : 32'(interval);
          free_id = -1;
          for (int i = TIMERS - 1; i >= 0; i--)
            if (!active[i]) free_id = i;
          if (tmo[31]) begin
            r.status = ST_NEG;
          end else if (free_id < 0) begin
            r.status = ST_FULL;
          end else begin
            ticks = (tmo < div) ? 32'd1 : tmo / div;
            active[free_id] = 1'b1;
            turns_left[free_id] = ROT_W'(ticks / SLOTS);
            slot_of[free_id] = SLOT_W'((ticks % SLOTS + slot_ptr) % SLOTS);
            r.result_id = ID_W'(free_id);
          end
          expected_rsp.push_back(r);
        end
        REQ_DEL: begin
          r.result_id = req.timer_id;
          if (!active[req.timer_id]) r.status = ST_INACTIVE;
          else active[req.timer_id] = 1'b0;
          expected_rsp.push_back(r);
        end
        REQ_TICK: begin
          for (int i = 0; i < TIMERS; i++) begin
            if (active[i] && slot_of[i] == slot_ptr) begin
              if (turns_left[i] != 0) begin
                turns_left[i]--;
              end else begin
                active[i] = 1'b0;
                r.result_id = ID_W'(i);
                r.expired = 1'b1;
                r.last = 1'b0;
                hits.push_back(r);
              end
            end
          end
          if (hits.size() == 0) begin
            r = '0;
            r.last = 1'b1;
            hits.push_back(r);
          end else begin
            r = hits.pop_back();
            r.last = 1'b1;
            hits.push_back(r);
          end
          foreach (hits[i]) expected_rsp.push_back(hits[i]);
          slot_ptr = slot_ptr + 1'b1;
        end
        default: ;  // unused request type: no state change, no beat
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(htw_rsp_t got);
      htw_rsp_t want;
      if (expected_rsp.size() == 0) begin
        report($sformatf("unexpected beat id=%0d status=%0d expired=%0d last=%0d",
                         got.result_id, got.status, got.expired, got.last));
        return;
      end
      want = expected_rsp.pop_front();
      if (got.result_id !== want.result_id)
        report($sformatf("result_id got %0d want %0d", got.result_id, want.result_id));
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.expired !== want.expired)
        report($sformatf("expired got %0d want %0d", got.expired, want.expired));
      if (got.last !== want.last)
        report($sformatf("last got %0d want %0d", got.last, want.last));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  htw_req_t         in_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  htw_rsp_t         out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [TI_W-1:0]  cfg_data_i = '0;

  wheel_scoreboard  sb = new();
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;

  hashed_timing_wheel u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // result side: check the beat taken at this edge, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_request(htw_req_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
  endtask

  task automatic write_interval(logic [TI_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_interval(v);
    cfg_valid_i <= 1'b0;
  endtask

  // all results in, then margin for a dropped beat that produced nothing
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic htw_req_t make_request(htw_req_e kind, logic [31:0] tmo,
                                            logic [ID_W-1:0] id);
    htw_req_t req;
    req.req_type = kind;
    req.timeout  = tmo;
    req.timer_id = id;
    return req;
  endfunction

  function automatic htw_req_t random_request();
    htw_req_t    req;
    int unsigned roll;
    int unsigned si;
    si = (sb.interval == 0) ? 1 : sb.interval;
    roll = $urandom_range(99);
    req.timeout  = $urandom;
    req.timer_id = $urandom_range(TIMERS - 1);
    if (roll < 5) begin
      req.req_type = REQ_NONE;
    end else if (roll < 42) begin
      req.req_type = REQ_ADD;
      case ($urandom_range(9))
        0: req.timeout = {1'b1, 31'($urandom)};
        1: req.timeout = {1'b0, 31'($urandom)};
        // mostly due within a couple of dozen ticks so expiries show up
        default: req.timeout = $urandom_range(24) * si + $urandom_range(si - 1, 0);
      endcase
    end else if (roll < 62) begin
      req.req_type = REQ_DEL;
    end else begin
      req.req_type = REQ_TICK;
    end
    return req;
  endfunction

  task automatic run_random(int unsigned count);
    htw_req_t    req;
    int unsigned done_cnt;
    done_cnt = 0;
    while (done_cnt < count) begin
      req = random_request();
      send_request(req);
      if (req.req_type != REQ_NONE) done_cnt++;
    end
  endtask

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 30;
    recv_stall_pct = 58;
    write_interval(16'd1);

    // directed: empty tick, short and extreme adds, bad timeout, delete paths
    send_request(make_request(REQ_TICK, 32'h0, 4'h0));
    send_request(make_request(REQ_ADD, 32'h0, 4'hf));
    send_request(make_request(REQ_ADD, 32'h7fff_ffff, 4'h0));
    send_request(make_request(REQ_ADD, 32'h8000_0000, 4'h0));
    send_request(make_request(REQ_DEL, 32'hffff_ffff, 4'h1));
    send_request(make_request(REQ_DEL, 32'h0, 4'h1));
    send_request(make_request(REQ_NONE, 32'h1234_5678, 4'h5));
    send_request(make_request(REQ_TICK, 32'h0, 4'h0));
    send_request(make_request(REQ_TICK, 32'h0, 4'h0));
    // fill the table: half expire next slot visit, half need one more turn
    for (int i = 0; i < TIMERS; i++)
      send_request(make_request(REQ_ADD, (i % 2) ? 32'd65 : 32'd1, 4'h0));
    send_request(make_request(REQ_ADD, 32'd3, 4'h0));
    send_request(make_request(REQ_TICK, 32'h0, 4'h0));
    send_request(make_request(REQ_TICK, 32'h0, 4'h0));
    wait_drained();

    write_interval(16'hffff);
    run_random(24);
    wait_drained();

    send_idle_pct  = 58;
    recv_stall_pct = 30;
    write_interval(16'h0000);
    run_random(24);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_interval(16'($urandom_range(300, 2)));
    run_random(24);
    wait_drained();

    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/htw_pkg.sv
rtl/core/htw_cell.sv
rtl/core/htw_div.sv
rtl/core/hashed_timing_wheel.sv
tb/tb_top.sv
